// ----- design/rht_pkg.sv -----
// Shared types and codes for the reference-counted handle table.
`timescale 1ns / 1ps
`default_nettype none

package rht_pkg;

  // request kinds
  localparam logic [1:0] K_GET     = 2'd0;
  localparam logic [1:0] K_RELEASE = 2'd1;
  localparam logic [1:0] K_UPDATE  = 2'd2;
  localparam logic [1:0] K_NONE    = 2'd3;

  // result status codes
  localparam logic [3:0] ST_HIT         = 4'd0;
  localparam logic [3:0] ST_INSERTED    = 4'd1;
  localparam logic [3:0] ST_FULL        = 4'd2;
  localparam logic [3:0] ST_REMOVED     = 4'd3;
  localparam logic [3:0] ST_DECREMENTED = 4'd4;
  localparam logic [3:0] ST_NOT_FOUND   = 4'd5;
  localparam logic [3:0] ST_NULL        = 4'd6;
  localparam logic [3:0] ST_REPLACED    = 4'd7;
  localparam logic [3:0] ST_IGNORED     = 4'd8;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [14:0] id;
    logic [31:0] handle;
    logic [7:0]  count;
  } rht_entry_t;

endpackage

`default_nettype wire

// ----- design/rht_table_mem.sv -----
// Table storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rht_table_mem #(
  parameter int DEPTH = 150,
  parameter int AW    = 8
) (
  input  wire                   clk,
  input  wire                   wr_en,
  input  wire  [AW-1:0]         wr_addr,
  input  rht_pkg::rht_entry_t   wr_data,
  input  wire                   rd_en,
  input  wire  [AW-1:0]         rd_addr,
  output rht_pkg::rht_entry_t   rd_data
);
  import rht_pkg::*;

  rht_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/rht_match.sv -----
// Shared key compare unit: matches an entry by asset id or by handle.
`timescale 1ns / 1ps
`default_nettype none

module rht_match (
  input  wire                  by_id,
  input  wire  [14:0]          key_id,
  input  wire  [31:0]          key_handle,
  input  rht_pkg::rht_entry_t  ent,
  output logic                 hit
);
  import rht_pkg::*;

  always_comb begin
    if (by_id) begin
      hit = (ent.id == key_id);
    end else begin
      hit = (ent.handle == key_handle);
    end
  end

endmodule

`default_nettype wire

// ----- design/refcounted_handle_table.sv -----
// Top level: reference-counted handle table with a sequential scan.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, kind, obj_id,         | request
//          | handle, new_handle                        |
//  out     | out_valid, out_stall, status, handle_out, | result
//          | slot, ref_count                           |
//
// No request is accepted until the sequencer returns to S_IDLE; a release
// that removes an entry also moves the last entry (S_FETCH, S_MOVE). The
// scan reads one entry per cycle through the table's single read port;
// requests settled without a search go straight to S_FINISH. Reset clears
// the state, out_valid and the entry count; the table needs no clearing.
// A result waits in the output register while out_stall is high; the
// sequencer holds in its final state until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_handle_table #(
  parameter int CAPACITY = 150
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  kind,
  input  wire  [14:0] obj_id,
  input  wire  [31:0] handle,
  input  wire  [31:0] new_handle,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [3:0]  status,
  output logic [31:0] handle_out,
  output logic [7:0]  slot,
  output logic [7:0]  ref_count
);
  import rht_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_FETCH  = 5'b00100,
    S_MOVE   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t     state;
  logic [7:0] entry_total;
  logic       pend_valid;

  logic [1:0]  req_kind;
  logic [14:0] req_id;
  logic [31:0] req_h;
  logic [31:0] req_nh;
  logic [7:0]  n;
  logic [7:0]  idx;
  logic [7:0]  pend_idx;

  logic [3:0]  res_status;
  logic [31:0] res_handle;
  logic [7:0]  res_slot;
  logic [7:0]  res_count;
  logic [7:0]  tot_res;
  logic        wr_pend;
  logic [AW-1:0] wr_addr;
  rht_entry_t  wr_data;

  logic        rd_en;
  logic [AW-1:0] rd_addr;
  rht_entry_t  rd_data;
  logic        match;

  logic accept, out_free, commit, imm, found, missed;
  logic [7:0] inc_cnt;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == S_FINISH) && out_free;
  assign found    = (state == S_SCAN) && pend_valid && match;
  assign missed   = (state == S_SCAN) && !(pend_valid && match) && (idx >= n);
  assign inc_cnt  = (rd_data.count == COUNT_MAX) ? COUNT_MAX : rd_data.count + 8'd1;

  // requests settled without a search
  assign imm = (kind == K_NONE)
            || ((kind == K_RELEASE) && (handle == 32'd0))
            || ((kind == K_UPDATE) && ((handle == 32'd0) || (new_handle == 32'd0)
                                       || (handle == new_handle)));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    if (state == S_FETCH) begin
      rd_en   = 1'b1;
      rd_addr = AW'(n - 8'd1);
    end else if ((state == S_SCAN) && (idx < n)) begin
      rd_en = 1'b1;
    end
  end

  rht_table_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (commit && wr_pend),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rht_match u_match (
    .by_id      (req_kind == K_GET),
    .key_id     (req_id),
    .key_handle (req_h),
    .ent        (rd_data),
    .hit        (match)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_total <= 8'd0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state      <= imm ? S_FINISH : S_SCAN;
            pend_valid <= 1'b0;
          end
        end
        S_SCAN: begin
          pend_valid <= (idx < n);
          if (found) begin
            if ((req_kind == K_RELEASE) && (rd_data.count <= 8'd1)) begin
              state <= S_FETCH;
            end else begin
              state <= S_FINISH;
            end
          end else if (missed) begin
            state <= S_FINISH;
          end
        end
        S_FETCH: state <= S_MOVE;
        S_MOVE:  state <= S_FINISH;
        S_FINISH: begin
          if (out_free) begin
            entry_total <= tot_res;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          req_kind   <= kind;
          req_id     <= obj_id;
          req_h      <= handle;
          req_nh     <= new_handle;
          n          <= entry_total;
          idx        <= 8'd0;
          res_status <= ((kind == K_NONE) || (handle == new_handle && kind == K_UPDATE
                         && handle != 32'd0 && new_handle != 32'd0)) ? ST_IGNORED : ST_NULL;
          res_handle <= 32'd0;
          res_slot   <= entry_total;
          res_count  <= 8'd0;
          tot_res    <= entry_total;
          wr_pend    <= 1'b0;
        end
      end
      S_SCAN: begin
        pend_idx <= idx;
        if (idx < n) begin
          idx <= idx + 8'd1;
        end
        if (found) begin
          res_slot <= pend_idx;
          wr_addr  <= pend_idx[AW-1:0];
          wr_pend  <= 1'b1;
          tot_res  <= n;
          unique case (req_kind)
            K_GET: begin
              res_status <= ST_HIT;
              res_handle <= rd_data.handle;
              res_count  <= inc_cnt;
              wr_data    <= '{id: rd_data.id, handle: rd_data.handle, count: inc_cnt};
            end
            K_RELEASE: begin
              res_handle <= 32'd0;
              if (rd_data.count <= 8'd1) begin
                res_status <= ST_REMOVED;
                res_count  <= 8'd0;
                tot_res    <= n - 8'd1;
              end else begin
                res_status <= ST_DECREMENTED;
                res_count  <= rd_data.count - 8'd1;
                wr_data    <= '{id: rd_data.id, handle: rd_data.handle,
                                count: rd_data.count - 8'd1};
              end
            end
            default: begin
              res_status <= ST_REPLACED;
              res_handle <= 32'd0;
              res_count  <= rd_data.count;
              wr_data    <= '{id: rd_data.id, handle: req_nh, count: rd_data.count};
            end
          endcase
        end else if (missed) begin
          res_slot   <= n;
          res_count  <= 8'd0;
          res_handle <= 32'd0;
          tot_res    <= n;
          wr_pend    <= 1'b0;
          if (req_kind == K_GET) begin
            if (n >= 8'(CAPACITY)) begin
              res_status <= ST_FULL;
            end else begin
              // append at the end of the live entries
              res_status <= ST_INSERTED;
              res_handle <= req_nh;
              res_count  <= 8'd1;
              tot_res    <= n + 8'd1;
              wr_pend    <= 1'b1;
              wr_addr    <= n[AW-1:0];
              wr_data    <= '{id: req_id, handle: req_nh, count: 8'd1};
            end
          end else begin
            res_status <= ST_NOT_FOUND;
          end
        end
      end
      S_MOVE: begin
        // last live entry fills the freed slot
        wr_data <= rd_data;
      end
      S_FINISH: begin
        if (out_free) begin
          status     <= res_status;
          handle_out <= res_handle;
          slot       <= res_slot;
          ref_count  <= res_count;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- dv/refcounted_handle_table_tb.sv -----
// Testbench for the reference-counted handle table: self-checking random and directed requests.
`timescale 1ns / 1ps

module refcounted_handle_table_tb;
  import rht_pkg::*;

  localparam int TABLE_DEPTH = 150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 160;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] handle_out;
    logic [7:0]  slot;
    logic [7:0]  ref_count;
  } table_result_t;

  // Mirror of the handle table; predicts one result per accepted request.
  class refcount_scoreboard;
    logic [14:0]   entry_id [TABLE_DEPTH];
    logic [31:0]   entry_handle [TABLE_DEPTH];
    logic [7:0]    entry_count [TABLE_DEPTH];
    int unsigned   entry_total;
    table_result_t pending_results [$];
    int unsigned   error_count;

    function new();
      entry_total = 0;
      error_count = 0;
    endfunction

    function int unsigned find_handle(logic [31:0] h);
      int unsigned i;
      i = 0;
      while (i < entry_total && entry_handle[i] != h) i++;
      return i;
    endfunction

    function void note_request(logic [1:0] k, logic [14:0] id, logic [31:0] h,
                               logic [31:0] nh);
      table_result_t res;
      int unsigned   i;
      int unsigned   last;
      res.status     = ST_IGNORED;
      res.handle_out = 32'd0;
      res.slot       = 8'(entry_total);
      res.ref_count  = 8'd0;
      case (k)
        K_GET: begin
          i = 0;
          while (i < entry_total && entry_id[i] != id) i++;
          if (i < entry_total) begin
            if (entry_count[i] != COUNT_MAX) entry_count[i]++;
            res.status     = ST_HIT;
            res.handle_out = entry_handle[i];
            res.slot       = 8'(i);
            res.ref_count  = entry_count[i];
          end else if (entry_total >= TABLE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            entry_id[i]     = id;
            entry_handle[i] = nh;
            entry_count[i]  = 8'd1;
            entry_total++;
            res.status     = ST_INSERTED;
            res.handle_out = nh;
            res.slot       = 8'(i);
            res.ref_count  = 8'd1;
          end
        end
        K_RELEASE: begin
          if (h == 32'd0) begin
            res.status = ST_NULL;
          end else begin
            i = find_handle(h);
            if (i >= entry_total) begin
              res.status = ST_NOT_FOUND;
            end else if (entry_count[i] <= 8'd1) begin
              // move the last live entry into the freed slot
              last            = entry_total - 1;
              entry_id[i]     = entry_id[last];
              entry_handle[i] = entry_handle[last];
              entry_count[i]  = entry_count[last];
              entry_total     = last;
              res.status      = ST_REMOVED;
              res.slot        = 8'(i);
            end else begin
              entry_count[i]--;
              res.status    = ST_DECREMENTED;
              res.slot      = 8'(i);
              res.ref_count = entry_count[i];
            end
          end
        end
        K_UPDATE: begin
          if (h == 32'd0 || nh == 32'd0) begin
            res.status = ST_NULL;
          end else if (h == nh) begin
            res.status = ST_IGNORED;
          end else begin
            i = find_handle(h);
            if (i >= entry_total) begin
              res.status = ST_NOT_FOUND;
            end else begin
              entry_handle[i] = nh;
              res.status      = ST_REPLACED;
              res.slot        = 8'(i);
              res.ref_count   = entry_count[i];
            end
          end
        end
        default: res.status = ST_IGNORED;
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [3:0] st, logic [31:0] ho, logic [7:0] sl,
                               logic [7:0] rc);
      table_result_t want;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("ERROR: unexpected result status=%0d handle_out=%h slot=%0d rc=%0d",
                   st, ho, sl, rc);
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.status || ho !== want.handle_out || sl !== want.slot ||
          rc !== want.ref_count) begin
        error_count++;
        if (error_count <= 10) begin
          $display("ERROR: expected status=%0d handle_out=%h slot=%0d ref_count=%0d",
                   want.status, want.handle_out, want.slot, want.ref_count);
          $display("       got      status=%0d handle_out=%h slot=%0d ref_count=%0d",
                   st, ho, sl, rc);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [14:0] obj_id;
  logic [31:0] handle;
  logic [31:0] new_handle;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  status;
  logic [31:0] handle_out;
  logic [7:0]  slot;
  logic [7:0]  ref_count;

  refcount_scoreboard sb;
  bit                 idle_enable;
  bit                 hold_request;
  int unsigned        cycle_count;
  logic [14:0]        id_pool [32];

  refcounted_handle_table #(
    .CAPACITY(TABLE_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .obj_id(obj_id),
    .handle(handle),
    .new_handle(new_handle),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .handle_out(handle_out),
    .slot(slot),
    .ref_count(ref_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Result checking and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (!rst && out_valid === 1'b1 && !out_stall)
      sb.check_result(status, handle_out, slot, ref_count);
  end

  // Result side: short random stalls, one long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_req(input logic [1:0] k, input logic [14:0] id,
                          input logic [31:0] h, input logic [31:0] nh);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    obj_id     <= id;
    handle     <= h;
    new_handle <= nh;
    do @(posedge clk); while (in_stall);
    sb.note_request(k, id, h, nh);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly live handles so releases and updates land on real entries.
  function automatic logic [31:0] pick_handle();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'd0;
    if (r < 4 || sb.entry_total == 0) return $urandom;
    return sb.entry_handle[$urandom_range(0, sb.entry_total - 1)];
  endfunction

  task automatic run_mixed(input int n_items, input int get_pct);
    int unsigned r;
    int unsigned sel;
    logic [1:0]  k;
    logic [14:0] id;
    logic [31:0] h;
    logic [31:0] nh;
    for (int n = 0; n < n_items; n++) begin
      r   = $urandom_range(0, 99);
      sel = $urandom_range(0, 9);
      id  = (sel == 0) ? 15'($urandom) : id_pool[$urandom_range(0, 31)];
      h   = pick_handle();
      nh  = $urandom;
      if (r < get_pct) begin
        k = K_GET;
        if (sel == 1) nh = 32'd0;
        else if (sel == 2) nh = pick_handle();
      end else if (r < get_pct + (92 - get_pct) / 2) begin
        k = K_RELEASE;
      end else if (r < 92) begin
        k = K_UPDATE;
        if (sel == 1) nh = 32'd0;
        else if (sel == 2) nh = h;
        else if (sel == 3) nh = pick_handle();
      end else begin
        k = K_NONE;
      end
      send_req(k, id, h, nh);
    end
  endtask

  initial begin
    logic [14:0] sat_id;
    int          guard;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    kind         <= K_GET;
    obj_id       <= 15'd0;
    handle       <= 32'd0;
    new_handle   <= 32'd0;
    idle_enable  = 1'b0;
    hold_request = 1'b0;
    cycle_count  = 0;
    sb = new();
    id_pool[0] = 15'd0;
    id_pool[1] = 15'h7FFF;
    for (int n = 2; n < 32; n++) id_pool[n] = 15'($urandom);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes and corner cases
    send_req(K_GET, 15'd0, 32'd0, 32'd0);                  // insert a null handle
    send_req(K_GET, 15'h7FFF, 32'd0, 32'hFFFF_FFFF);
    send_req(K_GET, 15'h7FFF, 32'd0, 32'h0000_1111);       // hit
    send_req(K_GET, 15'h2AAA, 32'd0, 32'hA5A5_5A5A);
    send_req(K_RELEASE, 15'd0, 32'd0, 32'd0);              // release of null
    send_req(K_RELEASE, 15'd0, 32'h1234_5678, 32'd0);      // not found
    send_req(K_RELEASE, 15'd0, 32'hFFFF_FFFF, 32'd0);      // decrement
    send_req(K_UPDATE, 15'd0, 32'd0, 32'd5);               // null old handle
    send_req(K_UPDATE, 15'd0, 32'hA5A5_5A5A, 32'd0);       // null new handle
    send_req(K_UPDATE, 15'd0, 32'hA5A5_5A5A, 32'hA5A5_5A5A);
    send_req(K_UPDATE, 15'd0, 32'hDEAD_BEEF, 32'd1);       // not found
    send_req(K_UPDATE, 15'h7FFF, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
    send_req(K_NONE, 15'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(K_RELEASE, 15'd0, 32'hFFFF_FFFF, 32'd0);      // remove, last entry moves
    send_req(K_GET, 15'h2AAA, 32'd0, 32'd7);               // hit on moved entry
    send_req(K_RELEASE, 15'd0, 32'h5A5A_A5A5, 32'd0);      // decrement the moved entry
    send_req(K_GET, 15'h5555, 32'd0, 32'h8000_0001);
    send_req(K_RELEASE, 15'h5555, 32'h8000_0001, 32'd0);
    send_req(K_GET, 15'd0, 32'd0, 32'hFFFF_FFFF);          // hit returns null handle

    idle_enable = 1'b1;
    run_mixed(150, 45);
    // hold off the result side while requests keep coming
    hold_request = 1'b1;
    run_mixed(15, 45);
    wait_for_results();
    run_mixed(130, 45);

    // fill the table, then probe it while full
    guard = 0;
    while (sb.entry_total < TABLE_DEPTH && guard < 600) begin
      send_req(K_GET, 15'($urandom), 32'd0, $urandom);
      guard++;
    end
    repeat (8) send_req(K_GET, 15'($urandom), 32'd0, $urandom);
    send_req(K_GET, sb.entry_id[TABLE_DEPTH - 1], 32'd0, $urandom);
    run_mixed(10, 30);

    // drive one count into saturation
    sat_id = sb.entry_id[0];
    repeat (260) send_req(K_GET, sat_id, 32'd0, $urandom);
    repeat (3) send_req(K_RELEASE, 15'd0, sb.entry_handle[0], 32'd0);

    idle_enable = 1'b0;
    run_mixed(220, 25);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0) sb.error_count++;
    if (sb.error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
